// ----- design/lnr_pkg.sv -----
// Shared types and constants for the line rasterizer core.
// Holds the stepping state layout, the pixel record and the status codes.
// Used by lnr_start, lnr_step and line_rasterizer_core.
`default_nettype none

package lnr_pkg;

   localparam int COORD_BITS = 9;
   localparam int COLOR_BITS = 16;
   localparam int ERR_W      = COORD_BITS + 3;
   localparam int INC_W      = COORD_BITS + 2;
   localparam int STATUS_W   = 2;

   localparam int REQ_FIELDS_W = COLOR_BITS + 4 * COORD_BITS;
   localparam int REQ_DATA_W   = ((REQ_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_FIELDS_W = 2 * COORD_BITS + COLOR_BITS;
   localparam int RSP_DATA_W   = ((RSP_FIELDS_W + 7) / 8) * 8;

   localparam logic CMD_START = 1'b0;
   localparam logic CMD_STEP  = 1'b1;

   localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] ST_SINGLE  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_NO_LINE = 2'd2;

   typedef logic [COORD_BITS-1:0] coord_type;
   typedef logic [COLOR_BITS-1:0] color_type;

   typedef struct packed {
      coord_type               major_pos;
      coord_type               minor_pos;
      coord_type               major_end;
      logic signed [ERR_W-1:0] error_term;
      logic [INC_W-1:0]        inc_straight;
      logic signed [ERR_W-1:0] inc_diagonal;
      logic                    major_dir;
      logic                    minor_dir;
      logic                    steep;
      color_type               line_color;
      logic                    active;
   } line_state_type;

   typedef struct packed {
      coord_type           x;
      coord_type           y;
      color_type           color;
      logic                last;
      logic [STATUS_W-1:0] status;
   } pixel_type;

endpackage

`default_nettype wire

// ----- design/lnr_start.sv -----
// Start decode: sorts the endpoints into major and minor axes and sets up
// the Bresenham increments and first pixel. Depends on lnr_pkg.
`default_nettype none

module lnr_start (
   input  lnr_pkg::line_state_type cur_state,
   input  lnr_pkg::color_type      color,
   input  lnr_pkg::coord_type      x_start,
   input  lnr_pkg::coord_type      y_start,
   input  lnr_pkg::coord_type      x_end,
   input  lnr_pkg::coord_type      y_end,
   output lnr_pkg::line_state_type next_state,
   output lnr_pkg::pixel_type      pixel
);
   import lnr_pkg::*;

   coord_type               adx;
   coord_type               ady;
   coord_type               dmaj;
   coord_type               dmin;
   logic                    is_steep;
   logic                    is_point;
   logic signed [ERR_W-1:0] dmaj_s;
   logic signed [ERR_W-1:0] dmin_s;
   logic signed [ERR_W-1:0] diff_s;

   always_comb begin
      adx      = (x_end >= x_start) ? x_end - x_start : x_start - x_end;
      ady      = (y_end >= y_start) ? y_end - y_start : y_start - y_end;
      is_steep = ady > adx;
      is_point = (x_start == x_end) && (y_start == y_end);
      dmaj     = is_steep ? ady : adx;
      dmin     = is_steep ? adx : ady;
      dmaj_s   = signed'(ERR_W'(dmaj));
      dmin_s   = signed'(ERR_W'(dmin));
      diff_s   = dmin_s - dmaj_s;

      next_state            = cur_state;
      next_state.line_color = color;
      pixel.x               = x_start;
      pixel.y               = y_start;
      pixel.color           = color;
      if (is_point) begin
         next_state.active = 1'b0;
         pixel.last        = 1'b1;
         pixel.status      = ST_SINGLE;
      end else begin
         next_state.steep        = is_steep;
         next_state.major_pos    = is_steep ? y_start : x_start;
         next_state.major_end    = is_steep ? y_end : x_end;
         next_state.minor_pos    = is_steep ? x_start : y_start;
         next_state.major_dir    = is_steep ? (y_end < y_start) : (x_end < x_start);
         next_state.minor_dir    = is_steep ? (x_end < x_start) : (y_end < y_start);
         next_state.inc_straight = {1'b0, dmin, 1'b0};
         next_state.inc_diagonal = diff_s + diff_s;
         next_state.error_term   = dmin_s + diff_s;
         next_state.active       = 1'b1;
         pixel.last              = 1'b0;
         pixel.status            = ST_OK;
      end
   end

endmodule

`default_nettype wire

// ----- design/lnr_step.sv -----
// Step logic: advances one pixel along the major axis, updates the signed
// error term and moves the minor axis on a diagonal step. Depends on lnr_pkg.
`default_nettype none

module lnr_step (
   input  lnr_pkg::line_state_type cur_state,
   output lnr_pkg::line_state_type next_state,
   output lnr_pkg::pixel_type      pixel
);
   import lnr_pkg::*;

   coord_type major_nxt;
   coord_type minor_nxt;
   logic      diag;
   logic      at_end;

   always_comb begin
      diag      = !cur_state.error_term[ERR_W-1];
      major_nxt = cur_state.major_dir ? cur_state.major_pos - 1'b1
                                      : cur_state.major_pos + 1'b1;
      minor_nxt = cur_state.minor_pos;
      if (diag) begin
         minor_nxt = cur_state.minor_dir ? cur_state.minor_pos - 1'b1
                                         : cur_state.minor_pos + 1'b1;
      end
      at_end = major_nxt == cur_state.major_end;

      next_state   = cur_state;
      pixel.x      = '0;
      pixel.y      = '0;
      pixel.color  = '0;
      pixel.last   = 1'b0;
      pixel.status = ST_NO_LINE;
      if (cur_state.active) begin
         next_state.major_pos  = major_nxt;
         next_state.minor_pos  = minor_nxt;
         next_state.error_term = diag
            ? cur_state.error_term + cur_state.inc_diagonal
            : cur_state.error_term + signed'(ERR_W'(cur_state.inc_straight));
         next_state.active     = !at_end;
         // swap the axes back for steep lines
         pixel.x      = cur_state.steep ? minor_nxt : major_nxt;
         pixel.y      = cur_state.steep ? major_nxt : minor_nxt;
         pixel.color  = cur_state.line_color;
         pixel.last   = at_end;
         pixel.status = ST_OK;
      end
   end

endmodule

`default_nettype wire

// ----- design/line_rasterizer_core.sv -----
// Bresenham line rasterizer: one command word in, one pixel word out.
// A start word (tuser = 0) loads two endpoints and a color and returns the
// first endpoint; each step word (tuser = 1) returns the next pixel, with
// rsp_tlast on the second endpoint. A step with no line active returns
// status 2 and zero data; equal endpoints return status 1 with tlast.
// A new word is taken each cycle as long as the result side keeps up; the
// input register loads at the accepting edge and the result register when
// the word moves on, which a stalled result side can hold back. The line
// state update (error add, sign test, axis increment) is combinational
// and sets that rate.
// Depends on lnr_pkg, lnr_start and lnr_step.
`default_nettype none

module line_rasterizer_core (
   input  wire                            clock,
   input  wire                            reset,
   input  wire                            req_tvalid,
   output logic                           req_tready,
   // lowest bit up: color, x_start, y_start, x_end, y_end, zero fill
   input  wire [lnr_pkg::REQ_DATA_W-1:0]  req_tdata,
   // cmd
   input  wire                            req_tuser,
   output logic                           rsp_tvalid,
   input  wire                            rsp_tready,
   // lowest bit up: pixel_x, pixel_y, pixel_color, zero fill
   output logic [lnr_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // status
   output logic [lnr_pkg::STATUS_W-1:0]   rsp_tuser,
   output logic                           rsp_tlast
);
   import lnr_pkg::*;

   localparam int XS_LO = COLOR_BITS;
   localparam int YS_LO = XS_LO + COORD_BITS;
   localparam int XE_LO = YS_LO + COORD_BITS;
   localparam int YE_LO = XE_LO + COORD_BITS;

   logic                  req_accept;
   logic                  advance;
   logic                  in_valid_ff;
   logic                  in_valid_in;
   logic                  in_cmd_ff;
   logic [REQ_DATA_W-1:0] in_data_ff;
   line_state_type        state_ff;
   line_state_type        state_in;
   line_state_type        start_state;
   line_state_type        step_state;
   pixel_type             start_pix;
   pixel_type             step_pix;
   pixel_type             pix_in;
   pixel_type             pix_ff;
   logic                  out_valid_ff;

   assign advance    = !out_valid_ff || rsp_tready;
   assign req_tready = !in_valid_ff || advance;
   assign req_accept = req_tvalid && req_tready;

   lnr_start u_start (
      .cur_state  (state_ff),
      .color      (in_data_ff[COLOR_BITS-1:0]),
      .x_start    (in_data_ff[XS_LO +: COORD_BITS]),
      .y_start    (in_data_ff[YS_LO +: COORD_BITS]),
      .x_end      (in_data_ff[XE_LO +: COORD_BITS]),
      .y_end      (in_data_ff[YE_LO +: COORD_BITS]),
      .next_state (start_state),
      .pixel      (start_pix)
   );

   lnr_step u_step (
      .cur_state  (state_ff),
      .next_state (step_state),
      .pixel      (step_pix)
   );

   always_comb begin
      if (in_cmd_ff == CMD_START) begin
         state_in = start_state;
         pix_in   = start_pix;
      end else begin
         state_in = step_state;
         pix_in   = step_pix;
      end
      in_valid_in = req_accept ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
   end

   // control and line state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         in_valid_ff <= in_valid_in;
         if (advance) begin
            out_valid_ff <= in_valid_ff;
         end
         if (advance && in_valid_ff) begin
            state_ff <= state_in;
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_cmd_ff  <= req_tuser;
         in_data_ff <= req_tdata;
      end
      if (advance && in_valid_ff) begin
         pix_ff <= pix_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'({pix_ff.color, pix_ff.y, pix_ff.x});
   assign rsp_tuser  = pix_ff.status;
   assign rsp_tlast  = pix_ff.last;

`ifndef ASSERT_OFF
   a_single_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == ST_SINGLE |-> rsp_tlast)
      else $error("single-pixel line not marked last");

   a_no_line_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == ST_NO_LINE |-> rsp_tdata == '0 && !rsp_tlast)
      else $error("idle step result carries data");

   a_idle_step: assert property (@(posedge clock) disable iff (reset)
      advance && in_valid_ff && in_cmd_ff == CMD_STEP && !state_ff.active
      |=> rsp_tvalid && rsp_tuser == ST_NO_LINE)
      else $error("step with no active line not flagged");

   a_last_ends_line: assert property (@(posedge clock) disable iff (reset)
      advance && in_valid_ff && in_cmd_ff == CMD_STEP && state_ff.active
      |=> rsp_tlast == !state_ff.active)
      else $error("last flag and active state disagree");
`endif

endmodule

`default_nettype wire

// ----- verif/tb_line_rasterizer_core.sv -----
// Self-checking testbench for line_rasterizer_core: drives start and step words,
// predicts every pixel with its own Bresenham stepper and compares field by field.
// Depends on lnr_pkg and line_rasterizer_core.
`default_nettype none

module tb_line_rasterizer_core;
   timeunit 1ns;
   timeprecision 1ps;

   import lnr_pkg::*;

   class raster_scoreboard;
      coord_type   major_pos, minor_pos, major_end;
      int          error_term, inc_straight, inc_diagonal;
      bit          major_dir, minor_dir, steep, active;
      color_type   line_color;
      pixel_type   pending_pixels[$];
      int          errors, starts, singles, no_line_steps, lines_ended, steep_lines;
      int          pixels_seen;

      function new();
         major_pos  = '0;
         minor_pos  = '0;
         major_end  = '0;
         line_color = '0;
      endfunction

      function coord_type step_axis(coord_type pos, bit dir);
         return dir ? pos - 1'b1 : pos + 1'b1;
      endfunction

      function pixel_type predict_pixel(logic cmd, logic [REQ_DATA_W-1:0] word);
         pixel_type px;
         color_type c;
         coord_type xs, ys, xe, ye;
         int adx, ady, dmaj, dmin;
         px = '0;
         if (cmd == CMD_START) begin
            c  = word[15:0];
            xs = word[24:16];
            ys = word[33:25];
            xe = word[42:34];
            ye = word[51:43];
            adx = (xe >= xs) ? int'(xe) - int'(xs) : int'(xs) - int'(xe);
            ady = (ye >= ys) ? int'(ye) - int'(ys) : int'(ys) - int'(ye);
            line_color = c;
            starts++;
            px.x = xs;
            px.y = ys;
            px.color = c;
            if (xs == xe && ys == ye) begin
               active = 0;
               singles++;
               px.last = 1'b1;
               px.status = ST_SINGLE;
               return px;
            end
            steep = ady > adx;
            if (steep) begin
               major_pos = ys;
               major_end = ye;
               minor_pos = xs;
               major_dir = ye < ys;
               minor_dir = xe < xs;
               dmaj = ady;
               dmin = adx;
               steep_lines++;
            end else begin
               major_pos = xs;
               major_end = xe;
               minor_pos = ys;
               major_dir = xe < xs;
               minor_dir = ye < ys;
               dmaj = adx;
               dmin = ady;
            end
            inc_straight = 2 * dmin;
            inc_diagonal = 2 * (dmin - dmaj);
            error_term   = 2 * dmin - dmaj;
            active = 1;
            px.status = ST_OK;
            return px;
         end
         if (!active) begin
            no_line_steps++;
            px.status = ST_NO_LINE;
            return px;
         end
         major_pos = step_axis(major_pos, major_dir);
         if (error_term >= 0) begin
            minor_pos = step_axis(minor_pos, minor_dir);
            error_term += inc_diagonal;
         end else begin
            error_term += inc_straight;
         end
         px.last = (major_pos == major_end);
         if (px.last) begin
            active = 0;
            lines_ended++;
         end
         px.x = steep ? minor_pos : major_pos;
         px.y = steep ? major_pos : minor_pos;
         px.color = line_color;
         px.status = ST_OK;
         return px;
      endfunction

      function void note_word(logic cmd, logic [REQ_DATA_W-1:0] word);
         pending_pixels.push_back(predict_pixel(cmd, word));
      endfunction

      function void report(string field, int unsigned want, logic [31:0] got);
         if (got !== want) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
         end
      endfunction

      function void check_pixel(logic [RSP_DATA_W-1:0] data, logic [STATUS_W-1:0] status,
                                logic last);
         pixel_type want;
         pixels_seen++;
         if (pending_pixels.size() == 0) begin
            errors++;
            $display("%0t: unexpected pixel, expected none, actual x=%0d y=%0d status=%0d",
                     $time, data[8:0], data[17:9], status);
            return;
         end
         want = pending_pixels.pop_front();
         report("pixel_x", want.x, data[8:0]);
         report("pixel_y", want.y, data[17:9]);
         report("pixel_color", want.color, data[33:18]);
         report("last", want.last, last);
         report("status", want.status, status);
      endfunction
   endclass

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int LONG_HOLD      = 300;
   localparam int PHASE_WORDS    = 340;
   localparam int SEND_IDLE[4]   = '{0, 88, 0, 19};
   localparam int RECV_STALL[4]  = '{0, 0, 88, 19};

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  req_tuser = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [STATUS_W-1:0]   rsp_tuser;
   logic                  rsp_tlast;

   raster_scoreboard pixels = new();
   int  words_sent = 0;
   int  send_idle = 0;
   int  recv_stall = 0;
   int  hold_left = 0;
   int  quiet_cycles = 0;
   bit  hold_req = 0;

   line_rasterizer_core u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #10 clock = ~clock;

   // Receiver: random stalls, plus one long hold-off on request.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left = hold_left - 1;
      end else if (hold_req) begin
         hold_req = 0;
         hold_left = LONG_HOLD;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= recv_stall);
      end
   end

   // Note inputs before checking outputs taken at the same edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready)
            pixels.note_word(req_tuser, req_tdata);
         if (rsp_tvalid && rsp_tready)
            pixels.check_pixel(rsp_tdata, rsp_tuser, rsp_tlast);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            quiet_cycles = 0;
         else
            quiet_cycles = quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no word moved for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("CHECK FAILED");
            $finish;
         end
      end
   end

   task automatic send_word(input logic cmd, input logic [REQ_DATA_W-1:0] word);
      while ($urandom_range(0, 99) < send_idle) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= word;
      do @(posedge clock); while (!(req_tvalid && req_tready));
      words_sent++;
   endtask

   task automatic start_line(input color_type c, input coord_type xs, input coord_type ys,
                             input coord_type xe, input coord_type ye);
      logic [REQ_DATA_W-1:0] word;
      word = '0;
      word[REQ_FIELDS_W-1:0] = {ye, xe, ys, xs, c};
      send_word(CMD_START, word);
   endtask

   // Step words carry random, ignored data.
   task automatic step_line(input int count);
      logic [REQ_DATA_W-1:0] word;
      repeat (count) begin
         word = REQ_DATA_W'({$urandom, $urandom});
         word[REQ_DATA_W-1:REQ_FIELDS_W] = '0;
         send_word(CMD_STEP, word);
      end
   endtask

   // Hold the sender until every accepted word has its pixel back.
   task automatic drain_pixels();
      req_tvalid <= 1'b0;
      while (pixels.pixels_seen < words_sent)
         @(posedge clock);
   endtask

   task automatic run_line();
      int        pick, span, dx, dy, length, steps;
      coord_type xs, ys, xe, ye;
      pick = $urandom_range(0, 99);
      span = (pick < 2) ? 511 : (pick < 25) ? 63 : 12;
      xs = coord_type'($urandom_range(0, 511));
      ys = coord_type'($urandom_range(0, 511));
      dx = $urandom_range(0, span);
      dy = $urandom_range(0, span);
      if ($urandom_range(0, 1))
         xe = (xs >= dx) ? coord_type'(int'(xs) - dx) : '0;
      else
         xe = (int'(xs) + dx > 511) ? 9'd511 : coord_type'(int'(xs) + dx);
      if ($urandom_range(0, 1))
         ye = (ys >= dy) ? coord_type'(int'(ys) - dy) : '0;
      else
         ye = (int'(ys) + dy > 511) ? 9'd511 : coord_type'(int'(ys) + dy);
      if ($urandom_range(0, 14) == 0) begin
         xe = xs;
         ye = ys;
      end
      start_line(color_type'($urandom_range(0, 65535)), xs, ys, xe, ye);
      dx = (xe >= xs) ? int'(xe) - int'(xs) : int'(xs) - int'(xe);
      dy = (ye >= ys) ? int'(ye) - int'(ys) : int'(ys) - int'(ye);
      length = (dx > dy) ? dx : dy;
      steps = length;
      pick = $urandom_range(0, 99);
      // drop the line midway, or step past its end
      if (pick < 12)
         steps = $urandom_range(0, length);
      else if (pick < 22)
         steps = length + $urandom_range(1, 2);
      step_line(steps);
   endtask

   initial begin
      int ph, target;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      send_idle = 19;
      recv_stall = 19;

      step_line(1);
      start_line(16'hFFFF, 9'd511, 9'd511, 9'd511, 9'd511);
      step_line(1);
      start_line(16'h0000, 9'd0, 9'd0, 9'd3, 9'd1);
      step_line(4);
      start_line(16'hA5A5, 9'd5, 9'd0, 9'd3, 9'd4);
      step_line(4);
      start_line(16'h1234, 9'd10, 9'd10, 9'd12, 9'd20);
      step_line(1);
      // restart while a line is still active
      start_line(16'h5A5A, 9'd511, 9'd0, 9'd508, 9'd3);
      step_line(3);
      start_line(16'h0F0F, 9'd0, 9'd511, 9'd0, 9'd509);
      step_line(2);
      start_line(16'hF0F0, 9'd2, 9'd7, 9'd0, 9'd7);
      step_line(2);
      drain_pixels();

      for (ph = 0; ph < 4; ph++) begin
         send_idle = SEND_IDLE[ph];
         recv_stall = RECV_STALL[ph];
         if (ph == 0)
            hold_req = 1;
         target = words_sent + PHASE_WORDS;
         while (words_sent < target)
            run_line();
         drain_pixels();
      end
      repeat (10) @(posedge clock);

      if (pixels.pending_pixels.size() != 0) begin
         pixels.errors++;
         $display("%0t: pixels missing, expected 0 pending, actual %0d pending",
                  $time, pixels.pending_pixels.size());
      end

      $display("Sent %0d words: %0d starts (%0d single pixel, %0d steep), %0d idle steps",
               words_sent, pixels.starts, pixels.singles, pixels.steep_lines,
               pixels.no_line_steps);
      $display("Checked %0d pixels, %0d lines stepped to their end, %0d mismatches",
               pixels.pixels_seen, pixels.lines_ended, pixels.errors);
      if (pixels.errors == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end
endmodule

`default_nettype wire

// ----- files.f -----
design/lnr_pkg.sv
design/lnr_start.sv
design/lnr_step.sv
design/line_rasterizer_core.sv
verif/tb_line_rasterizer_core.sv
